>>> sv/lfd_pkg.sv
package lfd_pkg;

    localparam logic [7:0]  RESYNC_BYTE = 8'hf0;
    localparam logic [15:0] END_MARK    = 16'hffff;
    localparam logic [15:0] COMMIT_WORD = 16'hf0ff;
    localparam logic [15:0] WORD_LIMIT  = 16'hff00;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_COMMIT = 2'd1;
    localparam logic [1:0] EV_BAD    = 2'd2;
    localparam logic [1:0] EV_RESYNC = 2'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [9:0] read_index;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  frame_event;
        logic        shown_buffer;
    } rsp_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] frame_event;
        logic       shown_buffer;
    } stage_t;

endpackage

>>> sv/lfd_ram.sv
module lfd_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] q
);

    logic [DW-1:0] store_mem [DEPTH];
    logic [DW-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= store_mem[raddr];
        end
    end

    assign q = q_reg;

endmodule

>>> sv/lfd_ctl.sv
module lfd_ctl #(
    parameter int FRAME_WORDS = 1024,
    parameter int AW          = 11,
    parameter int WPW         = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  lfd_pkg::req_t        req,
    output logic                 we,
    output logic [AW-1:0]        waddr,
    output logic [15:0]          wdata,
    output logic                 re,
    output logic [AW-1:0]        raddr,
    output lfd_pkg::stage_t      stage
);

    logic           shown_reg, shown_next;
    logic           high_reg, high_next;
    logic [7:0]     hold_reg, hold_next;
    logic           ems_reg, ems_next;
    logic           ok_reg, ok_next;
    logic [WPW-1:0] wp_reg, wp_next;
    logic [WPW-1:0] fill0_reg, fill0_next;
    logic [WPW-1:0] fill1_reg, fill1_next;

    logic [15:0]    word;
    logic           ok_t;
    logic           back;
    logic [WPW-1:0] fill_back;
    logic [WPW-1:0] fill_shown;
    logic [WPW-1:0] wp_inc;
    logic [1:0]     ev;

    assign word       = {req.rx_byte, hold_reg};
    assign back       = ~shown_reg;
    assign fill_back  = back ? fill1_reg : fill0_reg;
    assign fill_shown = shown_reg ? fill1_reg : fill0_reg;
    assign wp_inc     = wp_reg + WPW'(1);

    assign wdata = word;
    assign waddr = AW'((back ? 32'(FRAME_WORDS) : 32'd0) + 32'(wp_reg));
    assign raddr = AW'((shown_reg ? 32'(FRAME_WORDS) : 32'd0) + 32'(req.read_index));
    assign re    = accept && (req.command == lfd_pkg::CMD_READ);

    always_comb
    begin
        shown_next = shown_reg;
        high_next  = high_reg;
        hold_next  = hold_reg;
        ems_next   = ems_reg;
        ok_next    = ok_reg;
        wp_next    = wp_reg;
        fill0_next = fill0_reg;
        fill1_next = fill1_reg;
        ok_t       = ok_reg;
        ev         = lfd_pkg::EV_NONE;
        we         = 1'b0;
        if (accept && req.command == lfd_pkg::CMD_BYTE)
        begin
            if (!high_reg)
            begin
                if (ems_reg && req.rx_byte == lfd_pkg::RESYNC_BYTE)
                begin
                    wp_next  = '0;
                    ems_next = 1'b0;
                    ok_next  = 1'b1;
                    ev       = lfd_pkg::EV_RESYNC;
                end
                else
                begin
                    hold_next = req.rx_byte;
                    high_next = 1'b1;
                end
            end
            else
            begin
                high_next = 1'b0;
                if (word == lfd_pkg::END_MARK)
                begin
                    ok_next  = ~ems_reg;
                    ems_next = 1'b1;
                end
                else if (ems_reg && word == lfd_pkg::COMMIT_WORD)
                begin
                    if (ok_reg)
                    begin
                        shown_next = ~shown_reg;
                        ev         = lfd_pkg::EV_COMMIT;
                    end
                    else
                    begin
                        ev = lfd_pkg::EV_BAD;
                    end
                    wp_next  = '0;
                    ems_next = 1'b0;
                    ok_next  = 1'b1;
                end
                else
                begin
                    if (ems_reg || word > lfd_pkg::WORD_LIMIT)
                    begin
                        ok_t = 1'b0;
                    end
                    ok_next = ok_t;
                    if (ok_t && 32'(wp_reg) < 32'(FRAME_WORDS))
                    begin
                        we      = 1'b1;
                        wp_next = wp_inc;
                        if (wp_inc > fill_back)
                        begin
                            if (back)
                            begin
                                fill1_next = wp_inc;
                            end
                            else
                            begin
                                fill0_next = wp_inc;
                            end
                        end
                    end
                end
            end
        end
    end

    assign stage.hit          = (req.command == lfd_pkg::CMD_READ) &&
                                (32'(req.read_index) < 32'(fill_shown));
    assign stage.frame_event  = ev;
    assign stage.shown_buffer = shown_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg <= 1'b0;
            high_reg  <= 1'b0;
            hold_reg  <= '0;
            ems_reg   <= 1'b0;
            ok_reg    <= 1'b1;
            wp_reg    <= '0;
            fill0_reg <= '0;
            fill1_reg <= '0;
        end
        else
        begin
            shown_reg <= shown_next;
            high_reg  <= high_next;
            hold_reg  <= hold_next;
            ems_reg   <= ems_next;
            ok_reg    <= ok_next;
            wp_reg    <= wp_next;
            fill0_reg <= fill0_next;
            fill1_reg <= fill1_next;
        end
    end

endmodule

>>> sv/lfd_out.sv
module lfd_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  lfd_pkg::stage_t stage,
    input  logic [15:0]     mem_q,
    output logic            busy,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lfd_pkg::rsp_t   rsp
);

    logic            s1_valid_reg, s1_valid_next;
    lfd_pkg::stage_t s1_reg;
    logic            ov_reg, ov_next;
    lfd_pkg::rsp_t   out_reg;
    logic            s1_move;

    assign s1_move       = s1_valid_reg && (!ov_reg || !rsp_stall);
    assign busy          = s1_valid_reg && !s1_move;
    assign s1_valid_next = accept | (s1_valid_reg & ~s1_move);
    assign ov_next       = s1_move | (ov_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
        if (s1_move)
        begin
            out_reg.read_data    <= s1_reg.hit ? mem_q : 16'd0;
            out_reg.frame_event  <= s1_reg.frame_event;
            out_reg.shown_buffer <= s1_reg.shown_buffer;
        end
    end

    assign rsp_valid = ov_reg;
    assign rsp       = out_reg;

endmodule

>>> sv/led_frame_deframer_double_buffer.sv
// channel | handshake            | payload        | meaning
// req     | req_valid/req_stall  | lfd_pkg::req_t | received byte or shown-word read
// rsp     | rsp_valid/rsp_stall  | lfd_pkg::rsp_t | read word, frame event, shown buffer
//
// One item per cycle unless req_stall; each result goes through s1_reg, then out_reg.
// The single frame memory port pair sets this: one write and one registered read a cycle.
// Reset is immediate: per-buffer fill counts make unwritten words read as zero.
// req_stall rises only while the result stage is full and rsp is stalled.
module led_frame_deframer_double_buffer #(
    parameter int FRAME_WORDS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lfd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lfd_pkg::rsp_t rsp
);

    localparam int DEPTH = 2 * FRAME_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WPW   = $clog2(FRAME_WORDS + 1);

    logic            accept;
    logic            we;
    logic            re;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    logic [15:0]     wdata;
    logic [15:0]     mem_q;
    lfd_pkg::stage_t stage;

    assign accept = req_valid && !req_stall;

    lfd_ctl #(
        .FRAME_WORDS(FRAME_WORDS),
        .AW(AW),
        .WPW(WPW)
    ) u_ctl (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .req(req),
        .we(we),
        .waddr(waddr),
        .wdata(wdata),
        .re(re),
        .raddr(raddr),
        .stage(stage)
    );

    lfd_ram #(
        .DEPTH(DEPTH),
        .AW(AW),
        .DW(16)
    ) u_ram (
        .clk(clk),
        .we(we),
        .waddr(waddr),
        .wdata(wdata),
        .re(re),
        .raddr(raddr),
        .q(mem_q)
    );

    lfd_out u_out (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .stage(stage),
        .mem_q(mem_q),
        .busy(req_stall),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

endmodule

>>> sv/lfd_chk.sv
module lfd_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input lfd_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled rsp item changed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##2 rsp_valid)
        else $error("rsp item missing two cycles after req item");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("req stalled while rsp side free");

    a_read_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.read_data != 16'd0 |-> rsp.frame_event == lfd_pkg::EV_NONE)
        else $error("read item carries a frame event");

endmodule

bind led_frame_deframer_double_buffer lfd_chk u_chk (.*);
